@@ design/lcdns_pkg.sv @@
package lcdns_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;
   localparam int WAIT_W      = 20;
   localparam int LCD_COLUMNS = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NIBBLE_GAP = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_GAP   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWERUP    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLEAR_XTRA = 3'd4;

   // request actions
   localparam logic [2:0] ACT_TICK   = 3'd0;
   localparam logic [2:0] ACT_CMD    = 3'd1;
   localparam logic [2:0] ACT_DATA   = 3'd2;
   localparam logic [2:0] ACT_INIT   = 3'd3;
   localparam logic [2:0] ACT_CURSOR = 3'd4;
   localparam logic [2:0] ACT_CLEAR  = 3'd5;

   // sequencer phases
   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_POWERUP  = 3'd1;
   localparam logic [2:0] PH_HI_PULSE = 3'd2;
   localparam logic [2:0] PH_HI_GAP   = 3'd3;
   localparam logic [2:0] PH_LO_PULSE = 3'd4;
   localparam logic [2:0] PH_LO_GAP   = 3'd5;
   localparam logic [2:0] PH_EXTRA    = 3'd6;

   localparam logic [2:0] INIT_LEN = 3'd6;

   localparam logic [7:0] CMD_CLEAR   = 8'h01;
   localparam logic [7:0] CMD_ROW0    = 8'h80;
   localparam logic [7:0] CMD_ROW1    = 8'hC0;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] byte_value;
      logic [7:0] row;
      logic [7:0] column;
   } req_type;

   typedef struct packed {
      logic [3:0] data_nibble;
      logic       rs;
      logic       en;
      logic       busy_res;
      logic       rejected;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  pulse_ticks;
      logic [15:0] nibble_gap_ticks;
      logic [15:0] byte_gap_ticks;
      logic [19:0] powerup_ticks;
      logic [15:0] clear_extra_ticks;
   } cfg_type;

   function automatic logic [7:0] init_byte(input logic [2:0] step);
      logic [7:0] b;
      case (step)
         3'd0:    b = 8'h33;
         3'd1:    b = 8'h32;
         3'd2:    b = 8'h28;
         3'd3:    b = 8'h0C;
         3'd4:    b = 8'h01;
         3'd5:    b = 8'h82;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // zero count means one tick
   function automatic logic [WAIT_W-1:0] min_one16(input logic [15:0] v);
      return (v == 16'd0) ? WAIT_W'(1) : WAIT_W'(v);
   endfunction

   function automatic logic [WAIT_W-1:0] min_one8(input logic [7:0] v);
      return (v == 8'd0) ? WAIT_W'(1) : WAIT_W'(v);
   endfunction

endpackage

@@ design/char_lcd_nibble_sequencer.sv @@
// A request waits in the input register until the result register is free;
// then its result is loaded into the result register.
// Throughput: one request per cycle unless the result stalls; the input and
// result registers hold one request each; the state update is combinational.
// Reset (synchronous, active high) empties both registers, sets the
// sequencer idle with all timing state cleared, and loads the register
// defaults.
module char_lcd_nibble_sequencer
   import lcdns_pkg::*;
#(
   parameter int COLUMNS = LCD_COLUMNS
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;
   rsp_type core_result;

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    advance;
   logic    req_take;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   lcdns_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lcdns_core #(
      .COLUMNS (COLUMNS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (in_data_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // strobe only while a sequence runs
   a_en_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.en || rsp_data_ff.busy_res))
      else $error("en high while not busy");

   // a held result blocks the input stage
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !advance)
      else $error("result overwritten while stalled");

   // a new request only lands in a free or draining input register
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (!in_valid_ff || advance))
      else $error("input register overrun");

   // a processed request always yields a result next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result lost");
`endif

endmodule

@@ design/lcdns_csr.sv @@
module lcdns_csr
   import lcdns_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_ticks       <= 8'd1;
         cfg_ff.nibble_gap_ticks  <= 16'd100;
         cfg_ff.byte_gap_ticks    <= 16'd2000;
         cfg_ff.powerup_ticks     <= 20'd200000;
         cfg_ff.clear_extra_ticks <= 16'd2000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PULSE:      cfg_ff.pulse_ticks       <= csr_wdata[7:0];
            CSR_NIBBLE_GAP: cfg_ff.nibble_gap_ticks  <= csr_wdata[15:0];
            CSR_BYTE_GAP:   cfg_ff.byte_gap_ticks    <= csr_wdata[15:0];
            CSR_POWERUP:    cfg_ff.powerup_ticks     <= csr_wdata[19:0];
            CSR_CLEAR_XTRA: cfg_ff.clear_extra_ticks <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/lcdns_core.sv @@
module lcdns_core
   import lcdns_pkg::*;
#(
   parameter int COLUMNS = LCD_COLUMNS
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam logic [7:0] ColLimit = 8'(COLUMNS);

   logic [2:0]        phase_ff, phase_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic [7:0]        byte_ff, byte_in;
   logic              rs_ff, rs_in;
   logic [2:0]        init_ff, init_in;
   logic              extra_ff, extra_in;
   logic [3:0]        nibble_ff, nibble_in;

   logic              start;
   logic [7:0]        start_byte;
   logic              start_rs;
   logic              rej;

   always_comb begin
      phase_in   = phase_ff;
      wait_in    = wait_ff;
      byte_in    = byte_ff;
      rs_in      = rs_ff;
      init_in    = init_ff;
      extra_in   = extra_ff;
      nibble_in  = nibble_ff;
      start      = 1'b0;
      start_byte = 8'h00;
      start_rs   = 1'b0;
      rej        = 1'b0;

      if (step_en) begin
         if (req.action == ACT_TICK) begin
            if (phase_ff != PH_IDLE) begin
               if (wait_ff > WAIT_W'(1)) begin
                  wait_in = wait_ff - WAIT_W'(1);
               end else begin
                  wait_in = '0;
                  case (phase_ff)
                     PH_POWERUP: begin
                        init_in    = 3'd1;
                        start      = 1'b1;
                        start_byte = init_byte(3'd0);
                     end
                     PH_HI_PULSE: begin
                        phase_in = PH_HI_GAP;
                        wait_in  = min_one16(cfg.nibble_gap_ticks);
                     end
                     PH_HI_GAP: begin
                        nibble_in = byte_ff[3:0];
                        phase_in  = PH_LO_PULSE;
                        wait_in   = min_one8(cfg.pulse_ticks);
                     end
                     PH_LO_PULSE: begin
                        phase_in = PH_LO_GAP;
                        wait_in  = min_one16(cfg.byte_gap_ticks);
                     end
                     PH_LO_GAP: begin
                        if (init_ff != 3'd0 && init_ff < INIT_LEN) begin
                           init_in    = init_ff + 3'd1;
                           start      = 1'b1;
                           start_byte = init_byte(init_ff);
                        end else begin
                           init_in  = 3'd0;
                           extra_in = 1'b0;
                           if (extra_ff && cfg.clear_extra_ticks != 16'd0) begin
                              phase_in = PH_EXTRA;
                              wait_in  = WAIT_W'(cfg.clear_extra_ticks);
                           end else begin
                              phase_in = PH_IDLE;
                           end
                        end
                     end
                     default: begin
                        phase_in = PH_IDLE;
                     end
                  endcase
               end
            end
         end else if (req.action <= ACT_CLEAR) begin
            if (phase_ff != PH_IDLE) begin
               rej = 1'b1;
            end else begin
               case (req.action)
                  ACT_CMD: begin
                     start      = 1'b1;
                     start_byte = req.byte_value;
                  end
                  ACT_DATA: begin
                     start      = 1'b1;
                     start_byte = req.byte_value;
                     start_rs   = 1'b1;
                  end
                  ACT_INIT: begin
                     rs_in   = 1'b0;
                     init_in = 3'd1;
                     if (cfg.powerup_ticks == 20'd0) begin
                        start      = 1'b1;
                        start_byte = init_byte(3'd0);
                     end else begin
                        phase_in = PH_POWERUP;
                        wait_in  = cfg.powerup_ticks;
                     end
                  end
                  ACT_CURSOR: begin
                     if (req.column < ColLimit && req.row <= 8'd1) begin
                        start      = 1'b1;
                        start_byte = ((req.row == 8'd0) ? CMD_ROW0 : CMD_ROW1)
                                     | {4'h0, req.column[3:0]};
                     end else begin
                        rej = 1'b1;
                     end
                  end
                  default: begin
                     extra_in   = 1'b1;
                     start      = 1'b1;
                     start_byte = CMD_CLEAR;
                  end
               endcase
            end
         end
      end

      if (start) begin
         byte_in   = start_byte;
         rs_in     = start_rs;
         nibble_in = start_byte[7:4];
         phase_in  = PH_HI_PULSE;
         wait_in   = min_one8(cfg.pulse_ticks);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         wait_ff   <= '0;
         byte_ff   <= '0;
         rs_ff     <= 1'b0;
         init_ff   <= 3'd0;
         extra_ff  <= 1'b0;
         nibble_ff <= 4'h0;
      end else begin
         phase_ff  <= phase_in;
         wait_ff   <= wait_in;
         byte_ff   <= byte_in;
         rs_ff     <= rs_in;
         init_ff   <= init_in;
         extra_ff  <= extra_in;
         nibble_ff <= nibble_in;
      end
   end

   always_comb begin
      result.data_nibble = nibble_in;
      result.rs          = rs_in;
      result.en          = (phase_in == PH_HI_PULSE) || (phase_in == PH_LO_PULSE);
      result.busy_res    = (phase_in != PH_IDLE);
      result.rejected    = rej;
   end

endmodule
